// File: sv/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg
// Shared widths, register codes and types of the point rotate/project block.
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam int COORD_W  = 19;  // Q10.8 coordinates
  localparam int TRIG_W   = 16;  // Q1.14 trig values
  localparam int CD_W     = 19;
  localparam int PIX_W    = 12;
  localparam int COL_W    = 8;
  localparam int SCR_W    = 16;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int PROD_W   = COORD_W + TRIG_W;     // first products
  localparam int ROT_W    = PROD_W + 1;           // yaw sums
  localparam int ROT2_W   = ROT_W + TRIG_W;       // second products
  localparam int DEPTH_W  = ROT2_W + 2;           // ry, rz
  localparam int FOC_W    = PIX_W + 1;            // focal length as signed
  localparam int NUM_W    = DEPTH_W + FOC_W;      // dividends
  localparam int DEN_W    = DEPTH_W - 1;          // positive divisor
  localparam int DIV_BITS = 17;                   // quotient magnitude bits
  localparam int TRIAL_W  = DEN_W + DIV_BITS;
  localparam int DIV_STG  = DIV_BITS + 2;         // entry, range check, bits
  localparam int QS_W     = DIV_BITS + 1;
  localparam int SUM_W    = QS_W + 1;

  localparam int TRIG_FRAC = 14;
  localparam int CD_SHIFT  = 28;
  localparam int ONE_SHIFT = 36;

  localparam logic signed [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(64'd1 << ONE_SHIFT);
  localparam logic signed [SUM_W-1:0]   SCR_MAX   = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0]   SCR_MIN   = -SUM_W'(32768);

  typedef enum logic [2:0] {
    REG_COS_YAW   = 3'd0,
    REG_SIN_YAW   = 3'd1,
    REG_COS_PITCH = 3'd2,
    REG_SIN_PITCH = 3'd3,
    REG_CAM_DIST  = 3'd4,
    REG_FOCAL     = 3'd5,
    REG_CENTER_X  = 3'd6,
    REG_CENTER_Y  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_yaw;
    logic signed [TRIG_W-1:0] sin_yaw;
    logic signed [TRIG_W-1:0] cos_pitch;
    logic signed [TRIG_W-1:0] sin_pitch;
    logic signed [CD_W-1:0]   camera_distance;
    logic [PIX_W-1:0]         focal_length;
    logic [PIX_W-1:0]         center_x;
    logic [PIX_W-1:0]         center_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cos_yaw:         16'sd16384,
    sin_yaw:         16'sd0,
    cos_pitch:       16'sd16384,
    sin_pitch:       16'sd0,
    camera_distance: 19'sd30720,
    focal_length:    12'd800,
    center_x:        12'd640,
    center_y:        12'd400
  };

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic                    vld;
    logic signed [QS_W-1:0]  qx;
    logic signed [QS_W-1:0]  qy;
    color_t                  color;
  } div_out_t;

  typedef struct packed {
    logic signed [SCR_W-1:0] sx;
    logic signed [SCR_W-1:0] sy;
    color_t                  color;
  } result_t;

endpackage

// File: sv/point_rotate_project.sv
// ----------------------------------------------------------------------------
// point_rotate_project
// Rotates a 3D point by yaw then pitch, offsets depth, culls near points and
// projects onto the screen with a pipelined divide.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake             | word
//  ---------+-----------+-----------------------+------------------------------
//  in_      | input     | in_valid / in_ready   | x/y/z Q10.8, rgb
//  out_     | output    | out_valid / out_ready | screen x/y (sat 16b), rgb
//  cfg_     | input     | APB psel/penable      | eight settings, 32b data
//
//  One word enters per cycle while the pipe is not held; a word that
//  survives the depth cull passes five transform stages, nineteen divider
//  stages (entry, range check, one quotient bit each) and the output buffer.
//  The divider takes one word per cycle in every lane while the pipe is not held.
//  Reset is synchronous, active low, clears valid and pointer state and
//  loads the register defaults.
//  A stalled output fills a two-word skid buffer; in_ready is registered and
//  drops only once both words are held, and the whole pipe then holds.
//  Culled points leave a bubble, so nothing is emitted for them.
//
module point_rotate_project (
  input  logic                              clk,
  input  logic                              rst_n,
  // input word
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [prp_pkg::COORD_W-1:0] in_x_pos,
  input  logic signed [prp_pkg::COORD_W-1:0] in_y_pos,
  input  logic signed [prp_pkg::COORD_W-1:0] in_z_pos,
  input  logic [prp_pkg::COL_W-1:0]         in_red_in,
  input  logic [prp_pkg::COL_W-1:0]         in_green_in,
  input  logic [prp_pkg::COL_W-1:0]         in_blue_in,
  // result word
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [prp_pkg::SCR_W-1:0]  out_screen_x,
  output logic signed [prp_pkg::SCR_W-1:0]  out_screen_y,
  output logic [prp_pkg::COL_W-1:0]         out_red_out,
  output logic [prp_pkg::COL_W-1:0]         out_green_out,
  output logic [prp_pkg::COL_W-1:0]         out_blue_out,
  // settings
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [prp_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [prp_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic [prp_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import prp_pkg::*;

  cfg_t      cfg;
  logic      en;
  color_t    color_in, color_t5;
  logic      vld_t5;
  logic signed [NUM_W-1:0] num_x, num_y;
  logic [DEN_W-1:0]        den;
  div_out_t  dres;
  result_t   oword;

  assign color_in.red   = in_red_in;
  assign color_in.green = in_green_in;
  assign color_in.blue  = in_blue_in;

  // whole pipe advances unless the skid buffer is full
  assign in_ready = en;

  prp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // rotate, offset depth, cull, scale by focal length
  prp_transform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_valid),
    .x_pos     (in_x_pos),
    .y_pos     (in_y_pos),
    .z_pos     (in_z_pos),
    .color_in  (color_in),
    .cfg       (cfg),
    .out_vld   (vld_t5),
    .num_x     (num_x),
    .num_y     (num_y),
    .den       (den),
    .color_out (color_t5)
  );

  // perspective divide, both axes share the depth divisor
  prp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_t5),
    .num_x    (num_x),
    .num_y    (num_y),
    .den      (den),
    .color_in (color_t5),
    .res      (dres)
  );

  // add centre, saturate, buffer
  prp_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (dres),
    .center_x  (cfg.center_x),
    .center_y  (cfg.center_y),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (oword)
  );

  assign out_screen_x  = oword.sx;
  assign out_screen_y  = oword.sy;
  assign out_red_out   = oword.color.red;
  assign out_green_out = oword.color.green;
  assign out_blue_out  = oword.color.blue;

`ifndef NO_ASSERTIONS
  // a held pipe always has a word waiting at the output
  a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input held with no output word pending");

  // the pipe only stops after an output word was refused
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // no word leaves the divider while the pipe is held
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && dres.vld |=> dres.vld)
    else $error("divider word lost during stall");
`endif

endmodule

// File: sv/prp_cfg_regs.sv
// ----------------------------------------------------------------------------
// prp_cfg_regs
// APB-style register file holding the rotation, camera and screen settings.
// ----------------------------------------------------------------------------
module prp_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [prp_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [prp_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [prp_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output prp_pkg::cfg_t              cfg
);
  import prp_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_COS_YAW:   cfg_nxt.cos_yaw         = cfg_pwdata[TRIG_W-1:0];
        REG_SIN_YAW:   cfg_nxt.sin_yaw         = cfg_pwdata[TRIG_W-1:0];
        REG_COS_PITCH: cfg_nxt.cos_pitch       = cfg_pwdata[TRIG_W-1:0];
        REG_SIN_PITCH: cfg_nxt.sin_pitch       = cfg_pwdata[TRIG_W-1:0];
        REG_CAM_DIST:  cfg_nxt.camera_distance = cfg_pwdata[CD_W-1:0];
        REG_FOCAL:     cfg_nxt.focal_length    = cfg_pwdata[PIX_W-1:0];
        REG_CENTER_X:  cfg_nxt.center_x        = cfg_pwdata[PIX_W-1:0];
        REG_CENTER_Y:  cfg_nxt.center_y        = cfg_pwdata[PIX_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COS_YAW:   cfg_prdata = {16'b0, cfg_r.cos_yaw};
      REG_SIN_YAW:   cfg_prdata = {16'b0, cfg_r.sin_yaw};
      REG_COS_PITCH: cfg_prdata = {16'b0, cfg_r.cos_pitch};
      REG_SIN_PITCH: cfg_prdata = {16'b0, cfg_r.sin_pitch};
      REG_CAM_DIST:  cfg_prdata = {13'b0, cfg_r.camera_distance};
      REG_FOCAL:     cfg_prdata = {20'b0, cfg_r.focal_length};
      REG_CENTER_X:  cfg_prdata = {20'b0, cfg_r.center_x};
      REG_CENTER_Y:  cfg_prdata = {20'b0, cfg_r.center_y};
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: sv/prp_transform.sv
// ----------------------------------------------------------------------------
// prp_transform
// Five-stage rotate, depth offset and dividend scaling; culls near points.
// ----------------------------------------------------------------------------
module prp_transform (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [prp_pkg::COORD_W-1:0] x_pos,
  input  logic signed [prp_pkg::COORD_W-1:0] y_pos,
  input  logic signed [prp_pkg::COORD_W-1:0] z_pos,
  input  prp_pkg::color_t                   color_in,
  input  prp_pkg::cfg_t                     cfg,
  output logic                              out_vld,
  output logic signed [prp_pkg::NUM_W-1:0]  num_x,
  output logic signed [prp_pkg::NUM_W-1:0]  num_y,
  output logic [prp_pkg::DEN_W-1:0]         den,
  output prp_pkg::color_t                   color_out
);
  import prp_pkg::*;

  logic [4:0] vld_r;
  color_t     col_r [0:4];

  // stage 1: yaw and pitch products
  logic signed [PROD_W-1:0] xcy_r, zsy_r, xsy_r, zcy_r, ycp1_r, ysp1_r;
  // stage 2: yaw sums
  logic signed [ROT_W-1:0]  rx2_r, rzt_r;
  logic signed [PROD_W-1:0] ycp2_r, ysp2_r;
  // stage 3: pitch products of the turned depth
  logic signed [ROT2_W-1:0] rztsp_r, rztcp_r;
  logic signed [ROT_W-1:0]  rx3_r;
  logic signed [PROD_W-1:0] ycp3_r, ysp3_r;
  // stage 4: final y and depth
  logic signed [DEPTH_W-1:0] ry_r, rz_r;
  logic signed [ROT_W-1:0]   rx4_r;
  // stage 5: dividends
  logic signed [NUM_W-1:0]   numx_r, numy_r;
  logic [DEN_W-1:0]          den_r;

  logic signed [FOC_W-1:0] foc;
  logic                    near_ok;

  assign foc     = $signed({1'b0, cfg.focal_length});
  assign near_ok = rz_r > DEPTH_ONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3] & near_ok, vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r[0] <= color_in;
      col_r[1] <= col_r[0];
      col_r[2] <= col_r[1];
      col_r[3] <= col_r[2];
      col_r[4] <= col_r[3];

      xcy_r  <= PROD_W'(x_pos) * PROD_W'(cfg.cos_yaw);
      zsy_r  <= PROD_W'(z_pos) * PROD_W'(cfg.sin_yaw);
      xsy_r  <= PROD_W'(x_pos) * PROD_W'(cfg.sin_yaw);
      zcy_r  <= PROD_W'(z_pos) * PROD_W'(cfg.cos_yaw);
      ycp1_r <= PROD_W'(y_pos) * PROD_W'(cfg.cos_pitch);
      ysp1_r <= PROD_W'(y_pos) * PROD_W'(cfg.sin_pitch);

      rx2_r  <= ROT_W'(xcy_r) - ROT_W'(zsy_r);
      rzt_r  <= ROT_W'(xsy_r) + ROT_W'(zcy_r);
      ycp2_r <= ycp1_r;
      ysp2_r <= ysp1_r;

      rztsp_r <= ROT2_W'(rzt_r) * ROT2_W'(cfg.sin_pitch);
      rztcp_r <= ROT2_W'(rzt_r) * ROT2_W'(cfg.cos_pitch);
      rx3_r   <= rx2_r;
      ycp3_r  <= ycp2_r;
      ysp3_r  <= ysp2_r;

      ry_r  <= (DEPTH_W'(ycp3_r) <<< TRIG_FRAC) - DEPTH_W'(rztsp_r);
      rz_r  <= (DEPTH_W'(ysp3_r) <<< TRIG_FRAC) + DEPTH_W'(rztcp_r)
             + (DEPTH_W'(cfg.camera_distance) <<< CD_SHIFT);
      rx4_r <= rx3_r;

      numx_r <= (NUM_W'(rx4_r) * NUM_W'(foc)) <<< TRIG_FRAC;
      numy_r <= NUM_W'(ry_r) * NUM_W'(foc);
      den_r  <= rz_r[DEN_W-1:0];
    end
  end

  assign out_vld   = vld_r[4];
  assign num_x     = numx_r;
  assign num_y     = numy_r;
  assign den       = den_r;
  assign color_out = col_r[4];

endmodule

// File: sv/prp_divider.sv
// ----------------------------------------------------------------------------
// prp_divider
// Two-lane pipelined restoring divider, one quotient bit per stage,
// truncating toward zero with the magnitude clamped on overflow.
// ----------------------------------------------------------------------------
module prp_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [prp_pkg::NUM_W-1:0]  num_x,
  input  logic signed [prp_pkg::NUM_W-1:0]  num_y,
  input  logic [prp_pkg::DEN_W-1:0]         den,
  input  prp_pkg::color_t                   color_in,
  output prp_pkg::div_out_t                 res
);
  import prp_pkg::*;

  localparam int LAST = DIV_STG - 1;

  logic [DIV_STG-1:0]  vld_r, vld_nxt;
  logic [NUM_W-1:0]    remx_r [0:LAST];
  logic [NUM_W-1:0]    remx_nxt [0:LAST];
  logic [NUM_W-1:0]    remy_r [0:LAST];
  logic [NUM_W-1:0]    remy_nxt [0:LAST];
  logic [DIV_BITS-1:0] qx_r [0:LAST];
  logic [DIV_BITS-1:0] qx_nxt [0:LAST];
  logic [DIV_BITS-1:0] qy_r [0:LAST];
  logic [DIV_BITS-1:0] qy_nxt [0:LAST];
  logic [DIV_STG-1:0]  satx_r, satx_nxt, saty_r, saty_nxt;
  logic [DIV_STG-1:0]  negx_r, negx_nxt, negy_r, negy_nxt;
  logic [DEN_W-1:0]    den_r [0:LAST];
  logic [DEN_W-1:0]    den_nxt [0:LAST];
  color_t              col_r [0:LAST];
  color_t              col_nxt [0:LAST];

  logic [DIV_BITS-1:0] magx, magy;

  always_comb begin
    logic [TRIAL_W-1:0] trial;
    logic               gex, gey;
    // entry: split sign and magnitude
    vld_nxt[0]  = in_vld;
    negx_nxt[0] = num_x[NUM_W-1];
    negy_nxt[0] = num_y[NUM_W-1];
    remx_nxt[0] = num_x[NUM_W-1] ? -num_x : num_x;
    remy_nxt[0] = num_y[NUM_W-1] ? -num_y : num_y;
    qx_nxt[0]   = '0;
    qy_nxt[0]   = '0;
    satx_nxt[0] = 1'b0;
    saty_nxt[0] = 1'b0;
    den_nxt[0]  = den;
    col_nxt[0]  = color_in;
    for (int j = 0; j <= DIV_BITS; j++) begin
      trial = TRIAL_W'(den_r[j]) << (DIV_BITS - j);
      gex   = TRIAL_W'(remx_r[j]) >= trial;
      gey   = TRIAL_W'(remy_r[j]) >= trial;
      vld_nxt[j+1]  = vld_r[j];
      negx_nxt[j+1] = negx_r[j];
      negy_nxt[j+1] = negy_r[j];
      den_nxt[j+1]  = den_r[j];
      col_nxt[j+1]  = col_r[j];
      qx_nxt[j+1]   = qx_r[j];
      qy_nxt[j+1]   = qy_r[j];
      remx_nxt[j+1] = remx_r[j];
      remy_nxt[j+1] = remy_r[j];
      if (j == 0) begin
        // quotient would not fit the clamp range
        satx_nxt[1] = gex;
        saty_nxt[1] = gey;
      end else begin
        satx_nxt[j+1] = satx_r[j];
        saty_nxt[j+1] = saty_r[j];
        if (gex) begin
          remx_nxt[j+1] = NUM_W'(TRIAL_W'(remx_r[j]) - trial);
          qx_nxt[j+1][DIV_BITS-j] = 1'b1;
        end
        if (gey) begin
          remy_nxt[j+1] = NUM_W'(TRIAL_W'(remy_r[j]) - trial);
          qy_nxt[j+1][DIV_BITS-j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      remx_r <= remx_nxt;
      remy_r <= remy_nxt;
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
      satx_r <= satx_nxt;
      saty_r <= saty_nxt;
      negx_r <= negx_nxt;
      negy_r <= negy_nxt;
      den_r  <= den_nxt;
      col_r  <= col_nxt;
    end
  end

  assign magx = satx_r[LAST] ? '1 : qx_r[LAST];
  assign magy = saty_r[LAST] ? '1 : qy_r[LAST];

  assign res.vld   = vld_r[LAST];
  assign res.qx    = negx_r[LAST] ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
  assign res.qy    = negy_r[LAST] ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
  assign res.color = col_r[LAST];

endmodule

// File: sv/prp_out_buf.sv
// ----------------------------------------------------------------------------
// prp_out_buf
// Add screen centre, saturate, and hold results in a two-word skid buffer.
// ----------------------------------------------------------------------------
module prp_out_buf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  prp_pkg::div_out_t          res,
  input  logic [prp_pkg::PIX_W-1:0]  center_x,
  input  logic [prp_pkg::PIX_W-1:0]  center_y,
  output logic                       en,
  output logic                       out_valid,
  input  logic                       out_ready,
  output prp_pkg::result_t           out_word
);
  import prp_pkg::*;

  result_t          mem [0:1];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;
  logic signed [SUM_W-1:0] sumx, sumy;
  result_t          wword;

  function automatic logic signed [SCR_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [SCR_W-1:0] r;
    if (v > SCR_MAX) begin
      r = SCR_MAX[SCR_W-1:0];
    end else if (v < SCR_MIN) begin
      r = SCR_MIN[SCR_W-1:0];
    end else begin
      r = v[SCR_W-1:0];
    end
    return r;
  endfunction

  assign en        = (cnt_r != 2'd2);
  assign push      = en & res.vld;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid & out_ready;
  assign out_word  = mem[rd_ptr_r];

  assign sumx = SUM_W'(res.qx) + SUM_W'($signed({1'b0, center_x}));
  assign sumy = SUM_W'(res.qy) + SUM_W'($signed({1'b0, center_y}));

  always_comb begin
    wword.sx    = sat16(sumx);
    wword.sy    = sat16(sumy);
    wword.color = res.color;
    cnt_nxt     = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wword;
    end
  end

endmodule

// File: tb/tb_point_rotate_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_rotate_project
// Drives points through the rotate/project block under several register
// settings and handshake pressure, and checks every projected word against a
// bit-exact prediction of rotation, depth cull, divide and saturation.
// ----------------------------------------------------------------------------

// Holds the projected words still owed by the block, oldest first.
class projection_board;
  prp_pkg::result_t pending[$];
  int errors;
  int matched;

  function new();
    errors = 0;
    matched = 0;
  endfunction

  // Note the prediction for one accepted point (culled points add nothing).
  function void note_point(bit emits, prp_pkg::result_t r);
    if (emits) pending.insert(pending.size(), r);
  endfunction

  // Compare one projected word with the oldest prediction.
  function void check_word(prp_pkg::result_t got);
    prp_pkg::result_t want;
    if (pending.size() == 0) begin
      $error("unexpected word sx=%0d sy=%0d", got.sx, got.sy);
      errors++;
      return;
    end
    want = pending.pop_front();
    matched++;
    if (got.sx !== want.sx) begin
      $error("screen_x expected %0d actual %0d", want.sx, got.sx); errors++;
    end
    if (got.sy !== want.sy) begin
      $error("screen_y expected %0d actual %0d", want.sy, got.sy); errors++;
    end
    if (got.color.red !== want.color.red) begin
      $error("red_out expected %0d actual %0d", want.color.red, got.color.red); errors++;
    end
    if (got.color.green !== want.color.green) begin
      $error("green_out expected %0d actual %0d", want.color.green, got.color.green);
      errors++;
    end
    if (got.color.blue !== want.color.blue) begin
      $error("blue_out expected %0d actual %0d", want.color.blue, got.color.blue);
      errors++;
    end
  endfunction
endclass

module tb_point_rotate_project;
  import prp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_x_pos = '0, in_y_pos = '0, in_z_pos = '0;
  logic [COL_W-1:0] in_red_in = '0, in_green_in = '0, in_blue_in = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SCR_W-1:0] out_screen_x, out_screen_y;
  logic [COL_W-1:0] out_red_out, out_green_out, out_blue_out;

  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  point_rotate_project u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  projection_board board = new();
  cfg_t settings = CFG_RESET;   // shadow of the block's registers
  int send_idle_pct = 0;        // sender gap chance, percent
  int recv_idle_pct = 0;        // receiver stall chance, percent
  bit hold_off = 1'b0;          // long receiver stall in progress
  int points_sent = 0;
  int points_culled = 0;

  // Rotate, cull and project one point exactly as the block's fixed point does.
  function automatic bit project_point(logic signed [COORD_W-1:0] px,
                                       logic signed [COORD_W-1:0] py,
                                       logic signed [COORD_W-1:0] pz,
                                       color_t col, output result_t r);
    logic signed [127:0] x, y, z, cy, sy, cp, sp, cd, f;
    logic signed [127:0] rx, rzt, ry, rz, qx, qy, vx, vy;
    x = px; y = py; z = pz;
    cy = settings.cos_yaw; sy = settings.sin_yaw;
    cp = settings.cos_pitch; sp = settings.sin_pitch;
    cd = settings.camera_distance;
    f = $signed({116'd0, settings.focal_length});
    rx = x * cy - z * sy;
    rzt = x * sy + z * cy;
    ry = y * cp * 128'sd16384 - rzt * sp;
    rz = y * sp * 128'sd16384 + rzt * cp + (cd <<< CD_SHIFT);
    r = '0;
    if (rz <= (128'sd1 <<< ONE_SHIFT)) return 1'b0;
    // SystemVerilog signed division truncates toward zero
    qx = (rx * 128'sd16384 * f) / rz;
    qy = (ry * f) / rz;
    vx = qx + $signed({116'd0, settings.center_x});
    vy = qy + $signed({116'd0, settings.center_y});
    if (vx > 32767) vx = 32767;
    if (vx < -32768) vx = -32768;
    if (vy > 32767) vy = 32767;
    if (vy < -32768) vy = -32768;
    r.sx = vx[SCR_W-1:0];
    r.sy = vy[SCR_W-1:0];
    r.color = col;
    return 1'b1;
  endfunction

  // Write one register through the APB port and mirror it in the shadow.
  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'(4 * int'(idx)); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_COS_YAW:   settings.cos_yaw = val[TRIG_W-1:0];
      REG_SIN_YAW:   settings.sin_yaw = val[TRIG_W-1:0];
      REG_COS_PITCH: settings.cos_pitch = val[TRIG_W-1:0];
      REG_SIN_PITCH: settings.sin_pitch = val[TRIG_W-1:0];
      REG_CAM_DIST:  settings.camera_distance = val[CD_W-1:0];
      REG_FOCAL:     settings.focal_length = val[PIX_W-1:0];
      REG_CENTER_X:  settings.center_x = val[PIX_W-1:0];
      REG_CENTER_Y:  settings.center_y = val[PIX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_all(cfg_t c);
    write_reg(REG_COS_YAW, DATA_W'(c.cos_yaw));
    write_reg(REG_SIN_YAW, DATA_W'(c.sin_yaw));
    write_reg(REG_COS_PITCH, DATA_W'(c.cos_pitch));
    write_reg(REG_SIN_PITCH, DATA_W'(c.sin_pitch));
    write_reg(REG_CAM_DIST, DATA_W'(c.camera_distance));
    write_reg(REG_FOCAL, DATA_W'(c.focal_length));
    write_reg(REG_CENTER_X, DATA_W'(c.center_x));
    write_reg(REG_CENTER_Y, DATA_W'(c.center_y));
  endtask

  // Offer one point after an optional random idle gap and hold it until
  // accepted; valid stays high until the next gap or end_burst drops it.
  task automatic send_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                            logic signed [COORD_W-1:0] pz, color_t col);
    result_t r;
    bit emits;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_pos <= px; in_y_pos <= py; in_z_pos <= pz;
    in_red_in <= col.red; in_green_in <= col.green; in_blue_in <= col.blue;
    do @(posedge clk); while (!in_ready);
    emits = project_point(px, py, pz, col, r);
    board.note_point(emits, r);
    points_sent++;
    if (!emits) points_culled++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until all words are home, then let culled bubbles drain too.
  task automatic drain();
    end_burst();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random coordinate: mostly moderate, sometimes full range.
  function automatic logic signed [COORD_W-1:0] rand_coord();
    if ($urandom_range(9) < 7) return COORD_W'($signed($urandom_range(16384)) - 8192);
    return COORD_W'($urandom);
  endfunction

  function automatic color_t rand_color();
    return color_t'($urandom);
  endfunction

  function automatic logic signed [TRIG_W-1:0] rand_trig();
    if ($urandom_range(9) == 0) return TRIG_W'($urandom);   // beyond +-1.0
    return TRIG_W'($signed($urandom_range(32768)) - 16384);
  endfunction

  task automatic random_points(int n);
    repeat (n) send_point(rand_coord(), rand_coord(), rand_coord(), rand_color());
  endtask

  // Receiver: accept on handshake, stall at random or during a hold-off.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_word('{sx: out_screen_x, sy: out_screen_y,
                           color: '{red: out_red_out, green: out_green_out,
                                    blue: out_blue_out}});
      out_ready <= !hold_off &&
                   !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    cfg_t c;
    localparam logic signed [COORD_W-1:0] CMAX = 19'sd262143;
    localparam logic signed [COORD_W-1:0] CMIN = -19'sd262144;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, field extremes, cull boundary, saturation.
    send_point('0, '0, '0, '{8'h00, 8'hFF, 8'h00});
    send_point(CMAX, CMAX, '0, '{8'hFF, 8'h00, 8'hFF});
    send_point(CMIN, CMIN, '0, '{8'hAA, 8'h55, 8'hAA});
    send_point(19'sd256, -19'sd256, CMIN, '{8'h55, 8'hAA, 8'h55});   // behind camera
    send_point(19'sd100, 19'sd100, CMAX, '{8'h01, 8'h02, 8'h04});
    send_point(19'sd100, 19'sd0, -19'sd30464, '{8'h80, 8'h40, 8'h20}); // depth exactly 1
    send_point(19'sd100, 19'sd0, -19'sd30463, '{8'h10, 8'h08, 8'h7F}); // just past 1
    send_point(CMAX, CMIN, -19'sd30463, '{8'hFE, 8'hFD, 8'hFB});       // saturate
    send_point(CMIN, CMAX, -19'sd30463, '{8'hF7, 8'hEF, 8'hDF});
    drain();

    // Extreme settings: full-scale trig (mostly negative), max distance, max scale.
    c = '{cos_yaw: -16'sd16384, sin_yaw: 16'sd16384, cos_pitch: -16'sd16384,
          sin_pitch: -16'sd16384, camera_distance: 19'sd262143,
          focal_length: 12'd4095, center_x: 12'd4095, center_y: 12'd4095};
    load_all(c);
    send_point(CMAX, CMAX, CMAX, rand_color());
    send_point(CMIN, CMIN, CMIN, rand_color());
    send_point(CMAX, CMIN, CMAX, rand_color());
    send_point(19'sd1, -19'sd1, 19'sd0, rand_color());
    drain();
    // Zero focal length, zero centre, trig beyond range, minimum distance.
    c = '{cos_yaw: 16'sh7FFF, sin_yaw: 16'sh8000, cos_pitch: 16'sd0,
          sin_pitch: 16'sd16384, camera_distance: -19'sd262144,
          focal_length: 12'd0, center_x: 12'd0, center_y: 12'd0};
    load_all(c);
    send_point(CMAX, CMAX, CMIN, rand_color());
    send_point(CMIN, CMIN, CMAX, rand_color());
    send_point(19'sd512, CMAX, CMAX, rand_color());
    drain();
    write_reg(REG_FOCAL, 32'd4095);
    send_point(CMAX, CMAX, CMIN, rand_color());
    send_point(CMIN, 19'sd5, CMAX, rand_color());
    drain();

    // Random phases with varied settings and idling.
    for (int ph = 0; ph < 6; ph++) begin
      c.cos_yaw = rand_trig(); c.sin_yaw = rand_trig();
      c.cos_pitch = rand_trig(); c.sin_pitch = rand_trig();
      c.camera_distance = CD_W'($urandom_range(2) == 0 ? $urandom : $urandom_range(60000, 2000));
      c.focal_length = PIX_W'($urandom); c.center_x = PIX_W'($urandom);
      c.center_y = PIX_W'($urandom);
      load_all(c);
      send_idle_pct = (ph < 2) ? 17 : (ph < 4) ? 47 : 0;
      recv_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 17 : 0;
      random_points(200);
      drain();
    end

    // Back-pressure: hold the receiver off while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      random_points(60);
    join
    drain();

    $display("Sent %0d points (%0d culled), checked %0d projected words.",
             points_sent, points_culled, board.matched);
    $display("Covered reset, extreme and random settings under idling and back-pressure.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
